@@ hw/rtl/trilateration_three_anchors_macros.svh @@
// Assertion helpers for the trilateration block.
`ifndef TRILATERATION_THREE_ANCHORS_MACROS_SVH
`define TRILATERATION_THREE_ANCHORS_MACROS_SVH

// Checked outside reset.
`define TRILAT_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);

// Checked at every edge, reset included.
`define TRILAT_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) prop) else $error(msg);

`endif

@@ hw/rtl/trilat_pkg.sv @@
package trilat_pkg;

    localparam int CW   = 24;           // coordinate width
    localparam int FB   = 8;            // fractional bits
    localparam int TOLW = 8;            // tolerance register width
    localparam int RW   = CW - 1;       // range width
    localparam int DW   = CW + 1;       // coordinate difference
    localparam int SQW  = 2 * CW;       // square
    localparam int NW   = 2 * CW + 2;   // pair term
    localparam int PW   = 2 * DW;       // difference product
    localparam int EW   = 2 * CW + 3;   // determinant
    localparam int PLW  = CW + 1;       // low slice of a pair term
    localparam int PHW  = NW - PLW;     // high slice of a pair term
    localparam int NUMW = 3 * CW + 5;   // numerator
    localparam int VW   = 3 * CW + 6;   // divider datapath
    localparam int QW   = CW + 1;       // quotient bits kept

    localparam logic [TOLW-1:0] TOL_RESET = TOLW'(((1 << FB) + 50) / 100);

    typedef struct packed {
        logic signed [CW-1:0] anchor_a_x;
        logic signed [CW-1:0] anchor_a_y;
        logic        [RW-1:0] range_a;
        logic signed [CW-1:0] anchor_b_x;
        logic signed [CW-1:0] anchor_b_y;
        logic        [RW-1:0] range_b;
        logic signed [CW-1:0] anchor_c_x;
        logic signed [CW-1:0] anchor_c_y;
        logic        [RW-1:0] range_c;
    } t_in_word;

    typedef struct packed {
        logic signed [CW-1:0] pos_x;
        logic signed [CW-1:0] pos_y;
        logic                 found;
    } t_out_word;

    // Reordered anchors, as differences and squares.
    typedef struct packed {
        logic                     degen;
        logic signed [DW-1:0]     ay;
        logic signed [DW-1:0]     cy;
        logic signed [DW-1:0]     bx;
        logic signed [DW-1:0]     dx;
        logic [2:0][SQW-1:0]      sx;
        logic [2:0][SQW-1:0]      sy;
        logic [2:0][SQW-1:0]      sr;
    } t_prep_word;

    // Numerators and doubled determinant.
    typedef struct packed {
        logic                   bad;
        logic signed [NUMW-1:0] num_x;
        logic signed [NUMW-1:0] num_y;
        logic signed [EW:0]     den;
    } t_solve_word;

endpackage

@@ hw/rtl/trilat_prep.sv @@
module trilat_prep (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_en,
    input  logic [trilat_pkg::TOLW-1:0]  i_tol,
    input  logic                         i_valid,
    input  trilat_pkg::t_in_word         i_word,
    output logic                         o_valid,
    output trilat_pkg::t_prep_word       o_word
);
    import trilat_pkg::*;

    function automatic logic near(input logic [2:0] f, input logic [1:0] a,
                                  input logic [1:0] b);
        logic res;
        case (a ^ b)
            2'd1:    res = f[0];
            2'd2:    res = f[1];
            2'd3:    res = f[2];
            default: res = 1'b1;
        endcase
        return res;
    endfunction

    function automatic logic signed [CW-1:0] sel_c(input logic signed [CW-1:0] v0,
                                                   input logic signed [CW-1:0] v1,
                                                   input logic signed [CW-1:0] v2,
                                                   input logic [1:0] k);
        logic signed [CW-1:0] res;
        case (k)
            2'd0:    res = v0;
            2'd1:    res = v1;
            default: res = v2;
        endcase
        return res;
    endfunction

    function automatic logic [SQW-1:0] sel_s(input logic [SQW-1:0] v0,
                                             input logic [SQW-1:0] v1,
                                             input logic [SQW-1:0] v2,
                                             input logic [1:0] k);
        logic [SQW-1:0] res;
        case (k)
            2'd0:    res = v0;
            2'd1:    res = v1;
            default: res = v2;
        endcase
        return res;
    endfunction

    // stage 1: capture
    logic     r1_valid;
    t_in_word r1_word;

    // stage 2: equality flags and squares
    logic signed [CW-1:0] x [3];
    logic signed [CW-1:0] y [3];
    logic        [RW-1:0] r [3];
    logic        [2:0]    n_eqx, n_eqy;
    logic signed [SQW-1:0] n_sx [3];
    logic signed [SQW-1:0] n_sy [3];
    logic        [SQW-1:0] n_sr [3];
    logic                  r2_valid;
    logic        [2:0]     r2_eqx, r2_eqy;
    logic signed [CW-1:0]  r2_x [3];
    logic signed [CW-1:0]  r2_y [3];
    logic        [SQW-1:0] r2_sx [3];
    logic        [SQW-1:0] r2_sy [3];
    logic        [SQW-1:0] r2_sr [3];

    // stage 3: reorder
    logic [1:0]  p [3];
    logic [1:0]  t;
    t_prep_word  n_word;
    logic signed [CW-1:0] x0, x1, x2, y0, y1, y2;
    logic        r3_valid;
    t_prep_word  r3_word;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_valid <= 1'b0;
            r2_valid <= 1'b0;
            r3_valid <= 1'b0;
        end else if (i_en) begin
            r1_valid <= i_valid;
            r2_valid <= r1_valid;
            r3_valid <= r2_valid;
        end
    end

    always_comb begin
        x[0] = r1_word.anchor_a_x;  y[0] = r1_word.anchor_a_y;  r[0] = r1_word.range_a;
        x[1] = r1_word.anchor_b_x;  y[1] = r1_word.anchor_b_y;  r[1] = r1_word.range_b;
        x[2] = r1_word.anchor_c_x;  y[2] = r1_word.anchor_c_y;  r[2] = r1_word.range_c;
    end

    function automatic logic close(input logic signed [CW-1:0] a,
                                   input logic signed [CW-1:0] b,
                                   input logic [TOLW-1:0] tol);
        logic signed [DW-1:0] d;
        logic        [DW-1:0] m;
        d = DW'(a) - DW'(b);
        m = d[DW-1] ? DW'(-d) : DW'(d);
        return m < DW'(tol);
    endfunction

    always_comb begin
        n_eqx[0] = close(x[0], x[1], i_tol);
        n_eqx[1] = close(x[0], x[2], i_tol);
        n_eqx[2] = close(x[1], x[2], i_tol);
        n_eqy[0] = close(y[0], y[1], i_tol);
        n_eqy[1] = close(y[0], y[2], i_tol);
        n_eqy[2] = close(y[1], y[2], i_tol);
    end

    for (genvar g = 0; g < 3; g++) begin : g_sq
        assign n_sx[g] = x[g] * x[g];
        assign n_sy[g] = y[g] * y[g];
        assign n_sr[g] = SQW'(r[g]) * SQW'(r[g]);
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r1_word <= i_word;
            r2_eqx  <= n_eqx;
            r2_eqy  <= n_eqy;
            for (int k = 0; k < 3; k++) begin
                r2_x[k]  <= x[k];
                r2_y[k]  <= y[k];
                r2_sx[k] <= n_sx[k];
                r2_sy[k] <= n_sy[k];
                r2_sr[k] <= n_sr[k];
            end
            r3_word <= n_word;
        end
    end

    // four reorder steps on anchor indices
    always_comb begin
        p[0] = 2'd0;
        p[1] = 2'd1;
        p[2] = 2'd2;
        if (near(r2_eqx, p[0], p[1]) || near(r2_eqy, p[0], p[1])) begin
            t = p[0]; p[0] = p[2]; p[2] = t;
        end
        if (near(r2_eqx, p[0], p[2]) || near(r2_eqy, p[0], p[2])) begin
            t = p[0]; p[0] = p[1]; p[1] = t;
        end
        if (near(r2_eqy, p[0], p[1]) && near(r2_eqx, p[1], p[2])) begin
            t = p[1]; p[1] = p[2]; p[2] = t;
        end
        if (near(r2_eqx, p[0], p[2])) begin
            t = p[0]; p[0] = p[1]; p[1] = t;
        end
        t = p[0];
    end

    always_comb begin
        x0 = sel_c(r2_x[0], r2_x[1], r2_x[2], p[0]);
        x1 = sel_c(r2_x[0], r2_x[1], r2_x[2], p[1]);
        x2 = sel_c(r2_x[0], r2_x[1], r2_x[2], p[2]);
        y0 = sel_c(r2_y[0], r2_y[1], r2_y[2], p[0]);
        y1 = sel_c(r2_y[0], r2_y[1], r2_y[2], p[1]);
        y2 = sel_c(r2_y[0], r2_y[1], r2_y[2], p[2]);
        n_word.degen = (near(r2_eqx, p[0], p[1]) && near(r2_eqx, p[0], p[2])) ||
                       (near(r2_eqy, p[0], p[1]) && near(r2_eqy, p[0], p[2]));
        n_word.ay = DW'(y1) - DW'(y0);
        n_word.cy = DW'(y2) - DW'(y0);
        n_word.bx = DW'(x0) - DW'(x1);
        n_word.dx = DW'(x0) - DW'(x2);
        for (int k = 0; k < 3; k++) begin
            n_word.sx[k] = sel_s(r2_sx[0], r2_sx[1], r2_sx[2], p[k]);
            n_word.sy[k] = sel_s(r2_sy[0], r2_sy[1], r2_sy[2], p[k]);
            n_word.sr[k] = sel_s(r2_sr[0], r2_sr[1], r2_sr[2], p[k]);
        end
    end

    assign o_valid = r3_valid;
    assign o_word  = r3_word;

endmodule

@@ hw/rtl/trilat_solve.sv @@
module trilat_solve (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_en,
    input  logic                    i_valid,
    input  trilat_pkg::t_prep_word  i_word,
    output logic                    o_valid,
    output trilat_pkg::t_solve_word o_word
);
    import trilat_pkg::*;

    // stage 4: determinant products, pair terms
    logic signed [PW-1:0] n_pe1, n_pe2;
    logic signed [NW-1:0] n_nij, n_nik;
    logic                 r4_valid, r4_bad;
    logic signed [PW-1:0] r4_pe1, r4_pe2;
    logic signed [NW-1:0] r4_nij, r4_nik;
    logic signed [DW-1:0] r4_ay, r4_cy, r4_bx, r4_dx;

    // stage 5: determinant, sliced numerator products
    logic signed [EW-1:0]  n_e;
    logic signed [PHW-1:0] nij_h, nik_h;
    logic signed [PLW:0]   nij_l, nik_l;
    logic                  r5_valid, r5_bad;
    logic signed [EW-1:0]  r5_e;
    logic signed [DW+PHW-1:0] r5_ah, r5_ch, r5_bh, r5_dh;
    logic signed [DW+PLW:0]   r5_al, r5_cl, r5_bl, r5_dl;

    // stage 6: numerators
    logic signed [NUMW-1:0] ah, al, ch, cl, bh, bl, dh, dl;
    t_solve_word            n_word;
    logic                   r6_valid;
    t_solve_word            r6_word;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r4_valid <= 1'b0;
            r5_valid <= 1'b0;
            r6_valid <= 1'b0;
        end else if (i_en) begin
            r4_valid <= i_valid;
            r5_valid <= r4_valid;
            r6_valid <= r5_valid;
        end
    end

    assign n_pe1 = i_word.ay * i_word.dx;
    assign n_pe2 = i_word.cy * i_word.bx;
    assign n_nij = NW'(i_word.sx[0]) - NW'(i_word.sx[1]) + NW'(i_word.sy[0])
                 - NW'(i_word.sy[1]) + NW'(i_word.sr[1]) - NW'(i_word.sr[0]);
    assign n_nik = NW'(i_word.sx[0]) - NW'(i_word.sx[2]) + NW'(i_word.sy[0])
                 - NW'(i_word.sy[2]) + NW'(i_word.sr[2]) - NW'(i_word.sr[0]);

    assign n_e   = EW'(r4_pe1) - EW'(r4_pe2);
    assign nij_h = r4_nij[NW-1:PLW];
    assign nik_h = r4_nik[NW-1:PLW];
    assign nij_l = {1'b0, r4_nij[PLW-1:0]};
    assign nik_l = {1'b0, r4_nik[PLW-1:0]};

    always_comb begin
        ah = NUMW'(r5_ah);  al = NUMW'(r5_al);  ch = NUMW'(r5_ch);  cl = NUMW'(r5_cl);
        bh = NUMW'(r5_bh);  bl = NUMW'(r5_bl);  dh = NUMW'(r5_dh);  dl = NUMW'(r5_dl);
        n_word.bad   = r5_bad || (r5_e == '0);
        n_word.num_x = (ah <<< PLW) + al - (ch <<< PLW) - cl;
        n_word.num_y = (bh <<< PLW) + bl - (dh <<< PLW) - dl;
        n_word.den   = {r5_e, 1'b0};
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r4_bad <= i_word.degen || (i_word.ay == '0) || (i_word.bx == '0)
                      || (i_word.dx == '0);
            r4_pe1 <= n_pe1;
            r4_pe2 <= n_pe2;
            r4_nij <= n_nij;
            r4_nik <= n_nik;
            r4_ay  <= i_word.ay;
            r4_cy  <= i_word.cy;
            r4_bx  <= i_word.bx;
            r4_dx  <= i_word.dx;
            r5_bad <= r4_bad;
            r5_e   <= n_e;
            r5_ah  <= r4_ay * nik_h;
            r5_al  <= r4_ay * nik_l;
            r5_ch  <= r4_cy * nij_h;
            r5_cl  <= r4_cy * nij_l;
            r5_bh  <= r4_bx * nik_h;
            r5_bl  <= r4_bx * nik_l;
            r5_dh  <= r4_dx * nij_h;
            r5_dl  <= r4_dx * nij_l;
            r6_word <= n_word;
        end
    end

    assign o_valid = r6_valid;
    assign o_word  = r6_word;

endmodule

@@ hw/rtl/trilat_div.sv @@
module trilat_div (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_en,
    input  logic                           i_valid,
    input  logic                           i_bad,
    input  logic signed [trilat_pkg::NUMW-1:0] i_num,
    input  logic signed [trilat_pkg::EW:0]     i_den,
    output logic                           o_valid,
    output logic                           o_found,
    output logic signed [trilat_pkg::CW-1:0]   o_pos
);
    import trilat_pkg::*;

    localparam logic [QW-1:0] LIM = QW'(1) << (CW - 1);

    // D1: signs and magnitudes
    logic                r1_valid, r1_bad, r1_neg;
    logic [NUMW-1:0]     r1_an;
    logic [EW:0]         r1_ad;
    // D2: rounding offset
    logic                r2_valid, r2_bad, r2_neg;
    logic [VW-1:0]       r2_nn, r2_dd;
    // long division, one quotient bit per stage
    logic                r_valid [QW+1];
    logic                r_bad   [QW+1];
    logic                r_neg   [QW+1];
    logic                r_ovf   [QW+1];
    logic [VW-1:0]       r_rem   [QW+1];
    logic [VW-1:0]       r_dd    [QW+1];
    logic [QW-1:0]       r_q     [QW+1];
    logic [QW-1:0]       mag;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_valid   <= 1'b0;
            r2_valid   <= 1'b0;
            r_valid[0] <= 1'b0;
        end else if (i_en) begin
            r1_valid   <= i_valid;
            r2_valid   <= r1_valid;
            r_valid[0] <= r2_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r1_bad   <= i_bad;
            r1_neg   <= i_num[NUMW-1] ^ i_den[EW];
            r1_an    <= i_num[NUMW-1] ? NUMW'(-i_num) : NUMW'(i_num);
            r1_ad    <= i_den[EW] ? (EW+1)'(-i_den) : (EW+1)'(i_den);
            r2_bad   <= r1_bad;
            r2_neg   <= r1_neg;
            r2_nn    <= (VW'(r1_an) << 1) + VW'(r1_ad);
            r2_dd    <= VW'(r1_ad) << 1;
            r_bad[0] <= r2_bad;
            r_neg[0] <= r2_neg;
            r_ovf[0] <= r2_nn >= (r2_dd << QW);
            r_rem[0] <= r2_nn;
            r_dd[0]  <= r2_dd;
            r_q[0]   <= '0;
        end
    end

    for (genvar g = 0; g < QW; g++) begin : g_step
        localparam int B = QW - 1 - g;
        logic [VW-1:0] sh;
        logic          take;
        assign sh   = r_dd[g] << B;
        assign take = r_rem[g] >= sh;

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_valid[g+1] <= 1'b0;
            end else if (i_en) begin
                r_valid[g+1] <= r_valid[g];
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_bad[g+1] <= r_bad[g];
                r_neg[g+1] <= r_neg[g];
                r_ovf[g+1] <= r_ovf[g];
                r_dd[g+1]  <= r_dd[g];
                r_rem[g+1] <= take ? r_rem[g] - sh : r_rem[g];
                r_q[g+1]   <= r_q[g] | (QW'(take) << B);
            end
        end
    end

    // saturate to the signed coordinate range, ties already rounded away
    always_comb begin
        if (r_neg[QW]) begin
            mag = (r_ovf[QW] || r_q[QW] > LIM) ? LIM : r_q[QW];
        end else begin
            mag = (r_ovf[QW] || r_q[QW] > LIM - 1'b1) ? LIM - 1'b1 : r_q[QW];
        end
    end

    assign o_valid = r_valid[QW];
    assign o_found = !r_bad[QW];
    assign o_pos   = r_bad[QW] ? '0 : (r_neg[QW] ? CW'(~mag + 1'b1) : CW'(mag));

endmodule

@@ hw/rtl/trilateration_three_anchors.sv @@
// Channel   Direction  Handshake           Word
// input     in         i_valid / o_stall   i_word (t_in_word: three anchors and ranges)
// output    out        o_valid / i_stall   o_word (t_out_word: pos_x, pos_y, found)
// config    in         i_cfg_we            i_cfg_data (equal_tolerance)
//
// One word enters per cycle while o_stall is low; the pipe has 3 reorder, 3 multiply/sum,
// 3 sign/offset and 25 divider stages and 1 output register. The divider steps set
// the depth: one quotient bit per stage on a 78-bit remainder.
// Reset (i_rst_n low, synchronous) empties every stage and loads tolerance 3.
// While the output word is held by i_stall, the whole pipe freezes and o_stall
// is raised; nothing is dropped or repeated.
module trilateration_three_anchors (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_valid,
    input  trilat_pkg::t_in_word         i_word,
    output logic                         o_stall,
    output logic                         o_valid,
    output trilat_pkg::t_out_word        o_word,
    input  logic                         i_stall,
    input  logic                         i_cfg_we,
    input  logic [trilat_pkg::TOLW-1:0]  i_cfg_data
);
    import trilat_pkg::*;

`include "trilateration_three_anchors_macros.svh"

    logic            en;
    logic [TOLW-1:0] r_tol;
    logic            prep_valid, solve_valid;
    t_prep_word      prep_word;
    t_solve_word     solve_word;
    logic            x_valid, y_valid, x_found, y_found;
    logic signed [CW-1:0] x_pos, y_pos;
    logic            r_out_valid;
    t_out_word       r_out_word;
    t_out_word       n_out_word;

    // global advance: hold everything only while a result is refused
    assign en      = !(r_out_valid && i_stall);
    assign o_stall = !en;

    // tolerance register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tol <= TOL_RESET;
        end else if (i_cfg_we) begin
            r_tol <= i_cfg_data;
        end
    end

    // compare, square, reorder
    trilat_prep u_prep (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_tol   (r_tol),
        .i_valid (i_valid),
        .i_word  (i_word),
        .o_valid (prep_valid),
        .o_word  (prep_word)
    );

    // determinant and numerators
    trilat_solve u_solve (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (prep_valid),
        .i_word  (prep_word),
        .o_valid (solve_valid),
        .o_word  (solve_word)
    );

    // one divider lane per axis, in lockstep
    trilat_div u_div_x (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (solve_valid),
        .i_bad   (solve_word.bad),
        .i_num   (solve_word.num_x),
        .i_den   (solve_word.den),
        .o_valid (x_valid),
        .o_found (x_found),
        .o_pos   (x_pos)
    );

    trilat_div u_div_y (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (solve_valid),
        .i_bad   (solve_word.bad),
        .i_num   (solve_word.num_y),
        .i_den   (solve_word.den),
        .o_valid (y_valid),
        .o_found (y_found),
        .o_pos   (y_pos)
    );

    always_comb begin
        n_out_word.pos_x = x_pos;
        n_out_word.pos_y = y_pos;
        n_out_word.found = x_found;
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (en) begin
            r_out_valid <= x_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_out_word <= n_out_word;
        end
    end

    assign o_valid = r_out_valid;
    assign o_word  = r_out_word;

    // both divider lanes carry the same word
    `TRILAT_ASSERT(a_lanes_agree, x_valid == y_valid && (!x_valid || x_found == y_found), "divider lanes out of step")
    // no solution means a zero position
    `TRILAT_ASSERT(a_nofix_zero, r_out_valid && !r_out_word.found |-> r_out_word.pos_x == '0 && r_out_word.pos_y == '0, "unsolved word with nonzero position")
    // reset empties the output
    `TRILAT_ASSERT_ALWAYS(a_reset_empty, !i_rst_n |=> !o_valid, "output valid after reset")

endmodule

@@ bench/tb_trilateration_three_anchors.sv @@
`timescale 1ns / 100ps

module tb_trilateration_three_anchors;
    import trilat_pkg::*;

    // Pipe is 35 deep; settle time before a tolerance write and at the end.
    localparam int PIPE_SETTLE   = 45;
    // Long receiver hold-off, well past the pipe depth, so o_stall must rise.
    localparam int BACKLOG_HOLD  = 300;
    localparam int WATCHDOG_IDLE = 3000;
    localparam int SETS_PER_PASS = 150;

    typedef logic signed [127:0] t_wide;
    typedef struct {
        t_wide x;
        t_wide y;
        t_wide r;
    } t_anchor;

    logic             i_clk      = 1'b0;
    logic             i_rst_n    = 1'b0;
    logic             i_valid    = 1'b0;
    t_in_word         i_word     = '0;
    logic             o_stall;
    logic             o_valid;
    t_out_word        o_word;
    logic             i_stall    = 1'b0;
    logic             i_cfg_we   = 1'b0;
    logic [TOLW-1:0]  i_cfg_data = '0;

    trilateration_three_anchors dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (i_valid),
        .i_word     (i_word),
        .o_stall    (o_stall),
        .o_valid    (o_valid),
        .o_word     (o_word),
        .i_stall    (i_stall),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_data (i_cfg_data)
    );

    t_in_word        pending_sets[$];   // measurement sets waiting to be sent
    t_out_word       expected_fixes[$]; // predicted fixes in issue order
    logic [TOLW-1:0] tol_setting = TOL_RESET;
    int              error_count = 0;
    int              sets_sent   = 0;
    int              fixes_seen  = 0;
    int              idle_cycles = 0;

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    // ---------------------------------------------------------------
    // Predictor
    // ---------------------------------------------------------------

    function automatic bit near_equal(t_wide p, t_wide q, logic [TOLW-1:0] tol);
        t_wide d;
        d = p - q;
        if (d < 0)
            d = -d;
        return d < 128'(tol);
    endfunction

    // num / den rounded half away from zero, then clamped to CW bits.
    function automatic logic [CW-1:0] round_clamp(t_wide num, t_wide den);
        logic [127:0] an;
        logic [127:0] ad;
        logic [127:0] q;
        bit           neg;
        neg = (num < 0) != (den < 0);
        an  = (num < 0) ? -num : num;
        ad  = (den < 0) ? -den : den;
        q   = ((an << 1) + ad) / (ad << 1);
        if (neg)
            return (q > (128'd1 << (CW - 1))) ? {1'b1, {(CW-1){1'b0}}} : CW'(128'd0 - q);
        return (q > (128'd1 << (CW - 1)) - 1) ? {1'b0, {(CW-1){1'b1}}} : q[CW-1:0];
    endfunction

    function automatic t_out_word solve_fix(t_in_word w, logic [TOLW-1:0] tol);
        t_anchor   an[3];
        t_anchor   t;
        t_wide     ay, cy, bx, dx, e, nij, nik;
        t_out_word fix;
        fix     = '0;
        an[0].x = 128'(w.anchor_a_x);
        an[0].y = 128'(w.anchor_a_y);
        an[0].r = 128'(w.range_a);
        an[1].x = 128'(w.anchor_b_x);
        an[1].y = 128'(w.anchor_b_y);
        an[1].r = 128'(w.range_b);
        an[2].x = 128'(w.anchor_c_x);
        an[2].y = 128'(w.anchor_c_y);
        an[2].r = 128'(w.range_c);

        // reorder so that the divisors stay away from zero
        if (near_equal(an[0].x, an[1].x, tol) || near_equal(an[0].y, an[1].y, tol)) begin
            t = an[0]; an[0] = an[2]; an[2] = t;
        end
        if (near_equal(an[0].x, an[2].x, tol) || near_equal(an[0].y, an[2].y, tol)) begin
            t = an[0]; an[0] = an[1]; an[1] = t;
        end
        if (near_equal(an[0].y, an[1].y, tol) && near_equal(an[1].x, an[2].x, tol)) begin
            t = an[1]; an[1] = an[2]; an[2] = t;
        end
        if (near_equal(an[0].x, an[2].x, tol)) begin
            t = an[0]; an[0] = an[1]; an[1] = t;
        end
        if ((near_equal(an[0].x, an[1].x, tol) && near_equal(an[0].x, an[2].x, tol)) ||
            (near_equal(an[0].y, an[1].y, tol) && near_equal(an[0].y, an[2].y, tol)))
            return fix;

        ay = an[1].y - an[0].y;
        cy = an[2].y - an[0].y;
        bx = an[0].x - an[1].x;
        dx = an[0].x - an[2].x;
        e  = ay * dx - cy * bx;
        if (ay == 0 || bx == 0 || dx == 0 || e == 0)
            return fix;

        nij = an[0].x * an[0].x - an[1].x * an[1].x + an[0].y * an[0].y
            - an[1].y * an[1].y + an[1].r * an[1].r - an[0].r * an[0].r;
        nik = an[0].x * an[0].x - an[2].x * an[2].x + an[0].y * an[0].y
            - an[2].y * an[2].y + an[2].r * an[2].r - an[0].r * an[0].r;
        fix.pos_x = round_clamp(ay * nik - cy * nij, e <<< 1);
        fix.pos_y = round_clamp(bx * nik - dx * nij, e <<< 1);
        fix.found = 1'b1;
        return fix;
    endfunction

    // ---------------------------------------------------------------
    // Stimulus builders
    // ---------------------------------------------------------------

    function automatic t_in_word make_set(int ax, int ay, int ra, int bx, int by, int rb,
                                          int cx, int cy, int rc);
        t_in_word w;
        w.anchor_a_x = CW'(ax); w.anchor_a_y = CW'(ay); w.range_a = RW'(ra);
        w.anchor_b_x = CW'(bx); w.anchor_b_y = CW'(by); w.range_b = RW'(rb);
        w.anchor_c_x = CW'(cx); w.anchor_c_y = CW'(cy); w.range_c = RW'(rc);
        return w;
    endfunction

    // Consistent survey: random tag position, ranges measured to it, and now
    // and then a coordinate pulled close to another to exercise the reorder.
    function automatic t_in_word survey_set();
        int  spread, px, py, k, src;
        int  xs[3];
        int  ys[3];
        int  rs[3];
        real ddx, ddy;
        spread = 1 << $urandom_range(6, 21);
        px = $urandom_range(0, 2 * spread) - spread;
        py = $urandom_range(0, 2 * spread) - spread;
        for (k = 0; k < 3; k++) begin
            xs[k] = $urandom_range(0, 2 * spread) - spread;
            ys[k] = $urandom_range(0, 2 * spread) - spread;
        end
        if ($urandom_range(0, 3) == 0) begin
            k   = $urandom_range(0, 2);
            src = (k + $urandom_range(1, 2)) % 3;
            if ($urandom_range(0, 1))
                xs[k] = xs[src] + $urandom_range(0, 8) - 4;
            else
                ys[k] = ys[src] + $urandom_range(0, 8) - 4;
        end
        for (k = 0; k < 3; k++) begin
            ddx   = real'(xs[k] - px);
            ddy   = real'(ys[k] - py);
            rs[k] = $rtoi($sqrt(ddx * ddx + ddy * ddy) + 0.5) + $urandom_range(0, 3);
        end
        return make_set(xs[0], ys[0], rs[0], xs[1], ys[1], rs[1], xs[2], ys[2], rs[2]);
    endfunction

    function automatic t_in_word noise_set();
        return make_set($urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
                        $urandom, $urandom, $urandom);
    endfunction

    task automatic queue_random_sets(int count);
        int n;
        for (n = 0; n < count; n++) begin
            if ($urandom_range(0, 9) < 8)
                pending_sets.push_back(survey_set());
            else
                pending_sets.push_back(noise_set());
        end
    endtask

    task automatic queue_directed_sets();
        // plain well-posed triangle, tag near (4 m, 4 m)
        pending_sets.push_back(make_set(0, 0, 1448, 2560, 256, 1440, 512, 2560, 1452));
        // all x alike, then all y alike: rejected once the tolerance is 3 or more
        pending_sets.push_back(make_set(500, 0, 10, 501, 900, 20, 499, -700, 30));
        pending_sets.push_back(make_set(0, 77, 10, 900, 78, 20, -700, 76, 30));
        // everything zero, everything at the field limits
        pending_sets.push_back(make_set(0, 0, 0, 0, 0, 0, 0, 0, 0));
        pending_sets.push_back(make_set(8388607, -8388608, 8388607, -8388608, 8388607, 0,
                                        8388607, 8388607, 8388607));
        pending_sets.push_back(make_set(-8388608, -8388608, 8388607, 8388607, -8388608,
                                        8388607, -8388608, 8388607, 1));
        // near-equal pairs force the first two swaps
        pending_sets.push_back(make_set(0, 0, 700, 2, 1000, 800, 1000, 2, 900));
        pending_sets.push_back(make_set(300, 0, 700, 900, 600, 800, 302, 1200, 900));
        // first two share y, second and third share x
        pending_sets.push_back(make_set(0, 100, 500, 800, 101, 600, 801, 900, 700));
        // collinear: determinant vanishes
        pending_sets.push_back(make_set(0, 0, 100, 100, 100, 200, 200, 200, 300));
        // nearly collinear with long ranges: saturates both ways
        pending_sets.push_back(make_set(0, 0, 8388607, 256, 1, 0, 512, 3, 8388607));
        pending_sets.push_back(make_set(0, 0, 0, 256, 1, 8388607, 512, 3, 0));
        // differences one step beyond tolerance
        pending_sets.push_back(make_set(0, 0, 300, 3, 400, 350, 400, 3, 370));
    endtask

    // ---------------------------------------------------------------
    // Driver: one word per handshake, random gaps with quiet stretches
    // ---------------------------------------------------------------
    int gap_left = 0;

    always @(posedge i_clk) begin
        logic next_valid;
        next_valid = i_valid;
        if (!i_rst_n) begin
            next_valid = 1'b0;
        end else begin
            if (i_valid && !o_stall) begin
                expected_fixes.push_back(solve_fix(i_word, tol_setting));
                sets_sent++;
            end
            if (!i_valid || !o_stall) begin
                if (gap_left > 0) begin
                    gap_left--;
                    next_valid = 1'b0;
                end else if (pending_sets.size() > 0) begin
                    i_word     <= pending_sets.pop_front();
                    next_valid = 1'b1;
                    // every third block of 64 words goes back to back
                    gap_left = ((sets_sent / 64) % 3 == 1) ? 0 : $urandom_range(0, 3);
                end else begin
                    next_valid = 1'b0;
                end
            end
        end
        i_valid <= next_valid;
    end

    // ---------------------------------------------------------------
    // Monitor: compares fixes, drives stall with its own hold-offs
    // ---------------------------------------------------------------
    int stall_left = 0;

    task automatic report_mismatch(string field, longint got, longint want);
        $display("mismatch on fix %0d: %s got %0d expected %0d", fixes_seen, field, got, want);
        error_count++;
    endtask

    always @(posedge i_clk) begin
        t_out_word want;
        logic      next_stall;
        next_stall = 1'b0;
        if (i_rst_n) begin
            if (o_valid && !i_stall) begin
                if (expected_fixes.size() == 0) begin
                    $display("unexpected fix: x %0d y %0d found %0b",
                             o_word.pos_x, o_word.pos_y, o_word.found);
                    error_count++;
                end else begin
                    want = expected_fixes.pop_front();
                    if (o_word.pos_x !== want.pos_x)
                        report_mismatch("pos_x", o_word.pos_x, want.pos_x);
                    if (o_word.pos_y !== want.pos_y)
                        report_mismatch("pos_y", o_word.pos_y, want.pos_y);
                    if (o_word.found !== want.found)
                        report_mismatch("found", o_word.found, want.found);
                end
                fixes_seen++;
                if (fixes_seen == 150)
                    stall_left = BACKLOG_HOLD;
                else if ((fixes_seen / 50) % 3 == 2)
                    stall_left = 0;
                else
                    stall_left = $urandom_range(0, 3);
            end
            if (stall_left > 0) begin
                stall_left--;
                next_stall = 1'b1;
            end
        end
        i_stall <= next_stall;
    end

    // Watchdog: no traffic on either side for too long.
    always @(posedge i_clk) begin
        if ((i_valid && !o_stall) || (o_valid && !i_stall) || !i_rst_n) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= WATCHDOG_IDLE) begin
            $display("simulation failed");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    // ---------------------------------------------------------------
    // Sequence: passes at several tolerances, written only when idle
    // ---------------------------------------------------------------
    task automatic drain_pipe();
        while (pending_sets.size() > 0 || expected_fixes.size() > 0 || i_valid)
            @(posedge i_clk);
        repeat (PIPE_SETTLE) @(posedge i_clk);
    endtask

    task automatic write_tolerance(logic [TOLW-1:0] value);
        @(posedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_data  <= value;
        tol_setting = value;
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
    endtask

    initial begin
        logic [TOLW-1:0] tol_plan[4];
        int              p;
        tol_plan = '{8'd0, 8'd255, 8'(1 + $urandom_range(0, 60)), TOL_RESET};

        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // reset tolerance first, directed sets included
        queue_directed_sets();
        queue_random_sets(SETS_PER_PASS);
        drain_pipe();
        for (p = 0; p < 4; p++) begin
            write_tolerance(tol_plan[p]);
            queue_directed_sets();
            queue_random_sets(SETS_PER_PASS / 2 + (p == 2 ? SETS_PER_PASS : 0));
            drain_pipe();
        end

        if (error_count == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule
